/* design/tmb_pkg.sv */
// Package for the timer bank tick scheduler.
// Holds the operation codes, field widths and the cell control struct.
// No dependencies; compile first.
`timescale 1ns / 1ps

package tmb_pkg;

  localparam int unsigned MODE_W     = 2;
  localparam int unsigned SLOT_W     = 4;
  localparam int unsigned INTERVAL_W = 32;

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK  = 2'd0,
    MODE_START = 2'd1,
    MODE_STOP  = 2'd2,
    MODE_NONE  = 2'd3
  } tmb_mode_e;

  typedef struct packed {
    logic shift;
    logic load;
    logic stop;
  } tmb_cell_ctrl_t;

endpackage

/* design/tmb_in_if.sv */
// Input channel of the timer bank: valid/ready handshake with the command fields.
// Depends on tmb_pkg.
`timescale 1ns / 1ps

interface tmb_in_if import tmb_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [MODE_W-1:0]     mode;
  logic [SLOT_W-1:0]     slot;
  logic [INTERVAL_W-1:0] interval;
  logic                  one_shot;

  modport source (output valid, mode, slot, interval, one_shot, input ready);
  modport sink   (input valid, mode, slot, interval, one_shot, output ready);
endinterface

/* design/tmb_out_if.sv */
// Output channel of the timer bank: valid/ready handshake with one expiry record.
// Depends on tmb_pkg.
`timescale 1ns / 1ps

interface tmb_out_if import tmb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] expired_slot;
  logic              was_one_shot;
  logic              last;

  modport source (output valid, expired_slot, was_one_shot, last, input ready);
  modport sink   (input valid, expired_slot, was_one_shot, last, output ready);
endinterface

/* design/timer_bank_tick_scheduler_core.sv */
// Timer bank tick scheduler, top level.
// Usage: commands arrive on in_i (tick, start slot, stop slot); expiry records leave
// on out_o, one per expiring slot, in ascending slot order, the final one of a tick
// marked by last. Both channels use a valid/ready handshake per transaction.
// Start and stop take effect in the cycle they are accepted and never give a result.
// A tick rotates the ring of NUM_SLOTS slot cells once through a shared decrementer
// at its head, one slot per cycle unless the rotation is held, and then hands over its
// final record in the flush state; in_i.ready is low during the scan and the flush.
// An expiry record is held back until the next expiry or the end of the scan so that
// last can be set; it moves into the output register when the head steps past the
// next expiring slot, or in the flush state.
// If out_o stalls while the output register and the held record are both full, the
// rotation holds at the next expiring slot and the flush waits; nothing is lost.
// Reset clears all active marks and the control state; periods and counts are
// undefined until a start writes them, and idle slots are never reported.
// Depends on tmb_pkg, tmb_in_if, tmb_out_if, tmb_cell and tmb_head.
`timescale 1ns / 1ps

module timer_bank_tick_scheduler_core import tmb_pkg::*; #(
  parameter int unsigned NUM_SLOTS  = 16,
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tmb_in_if.sink      in_i,
  tmb_out_if.source   out_o
);

  localparam int unsigned STEP_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CELL_IDX_W = (STEP_W > SLOT_W) ? STEP_W : SLOT_W;
  localparam int unsigned IVAL_W     = (COUNT_BITS > INTERVAL_W) ? COUNT_BITS : INTERVAL_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } tmb_state_e;

  tmb_state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;

  logic              pend_valid_q, pend_valid_d;
  logic [SLOT_W-1:0] pend_slot_q, pend_slot_d;
  logic              pend_one_shot_q, pend_one_shot_d;

  logic              out_valid_q, out_valid_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic              out_one_shot_q, out_one_shot_d;
  logic              out_last_q, out_last_d;

  logic [COUNT_BITS-1:0] cell_period [NUM_SLOTS];
  logic [COUNT_BITS-1:0] cell_count  [NUM_SLOTS];
  logic                  cell_active [NUM_SLOTS];
  logic                  cell_one_shot [NUM_SLOTS];

  logic [COUNT_BITS-1:0] head_count;
  logic                  head_active;
  logic                  head_expire;

  logic [IVAL_W-1:0]     ival_ext;
  logic [COUNT_BITS-1:0] ival;
  logic [CELL_IDX_W-1:0] slot_ext;
  logic [CELL_IDX_W-1:0] step_ext;

  logic in_fire, out_free, do_step, do_start, do_stop;

  assign ival_ext = IVAL_W'(in_i.interval);
  assign ival     = ival_ext[COUNT_BITS-1:0];
  assign slot_ext = CELL_IDX_W'(in_i.slot);
  assign step_ext = CELL_IDX_W'(step_q);

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign do_start   = in_fire && (in_i.mode == MODE_START);
  assign do_stop    = in_fire && (in_i.mode == MODE_STOP);
  assign out_free   = !out_valid_q || out_o.ready;

  // The head slot may advance unless it expires while a held record cannot move on.
  assign do_step = (state_q == ST_SCAN) && (!head_expire || !pend_valid_q || out_free);

  tmb_head #(
    .COUNT_BITS(COUNT_BITS)
  ) u_head (
    .period_i   (cell_period[0]),
    .count_i    (cell_count[0]),
    .active_i   (cell_active[0]),
    .one_shot_i (cell_one_shot[0]),
    .count_o    (head_count),
    .active_o   (head_active),
    .expire_o   (head_expire)
  );

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    tmb_cell_ctrl_t        ctrl;
    logic [COUNT_BITS-1:0] nxt_period, nxt_count;
    logic                  nxt_active, nxt_one_shot;
    logic                  hit;

    assign hit        = (slot_ext == CELL_IDX_W'(i));
    assign ctrl.shift = do_step;
    assign ctrl.load  = do_start && hit;
    assign ctrl.stop  = do_stop && hit;

    if (i == NUM_SLOTS - 1) begin : g_tail
      assign nxt_period   = cell_period[0];
      assign nxt_count    = head_count;
      assign nxt_active   = head_active;
      assign nxt_one_shot = cell_one_shot[0];
    end else begin : g_mid
      assign nxt_period   = cell_period[i+1];
      assign nxt_count    = cell_count[i+1];
      assign nxt_active   = cell_active[i+1];
      assign nxt_one_shot = cell_one_shot[i+1];
    end

    tmb_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk_i            (clk_i),
      .rst_ni           (rst_ni),
      .ctrl_i           (ctrl),
      .load_interval_i  (ival),
      .load_one_shot_i  (in_i.one_shot),
      .shift_period_i   (nxt_period),
      .shift_count_i    (nxt_count),
      .shift_active_i   (nxt_active),
      .shift_one_shot_i (nxt_one_shot),
      .period_o         (cell_period[i]),
      .count_o          (cell_count[i]),
      .active_o         (cell_active[i]),
      .one_shot_o       (cell_one_shot[i])
    );
  end

  always_comb begin
    state_d         = state_q;
    step_d          = step_q;
    pend_valid_d    = pend_valid_q;
    pend_slot_d     = pend_slot_q;
    pend_one_shot_d = pend_one_shot_q;
    out_valid_d     = out_valid_q;
    out_slot_d      = out_slot_q;
    out_one_shot_d  = out_one_shot_q;
    out_last_d      = out_last_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_i.mode == MODE_TICK)) begin
          state_d = ST_SCAN;
          step_d  = '0;
        end
      end
      ST_SCAN: begin
        if (do_step) begin
          if (head_expire) begin
            if (pend_valid_q) begin
              out_valid_d    = 1'b1;
              out_slot_d     = pend_slot_q;
              out_one_shot_d = pend_one_shot_q;
              out_last_d     = 1'b0;
            end
            pend_valid_d    = 1'b1;
            pend_slot_d     = step_ext[SLOT_W-1:0];
            pend_one_shot_d = cell_one_shot[0];
          end
          if (step_q == STEP_W'(NUM_SLOTS - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            step_d = step_q + STEP_W'(1);
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d    = 1'b1;
          out_slot_d     = pend_slot_q;
          out_one_shot_d = pend_one_shot_q;
          out_last_d     = 1'b1;
          pend_valid_d   = 1'b0;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      step_q       <= step_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q     <= pend_slot_d;
    pend_one_shot_q <= pend_one_shot_d;
    out_slot_q      <= out_slot_d;
    out_one_shot_q  <= out_one_shot_d;
    out_last_q      <= out_last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.expired_slot = out_slot_q;
  assign out_o.was_one_shot = out_one_shot_q;
  assign out_o.last         = out_last_q;

endmodule

/* design/tmb_cell.sv */
// One timer slot cell of the rotating ring: period, count, active and one-shot marks.
// Depends on tmb_pkg for the control struct.
`timescale 1ns / 1ps

module tmb_cell import tmb_pkg::*; #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tmb_cell_ctrl_t        ctrl_i,
  input  logic [COUNT_BITS-1:0] load_interval_i,
  input  logic                  load_one_shot_i,
  input  logic [COUNT_BITS-1:0] shift_period_i,
  input  logic [COUNT_BITS-1:0] shift_count_i,
  input  logic                  shift_active_i,
  input  logic                  shift_one_shot_i,
  output logic [COUNT_BITS-1:0] period_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  active_o,
  output logic                  one_shot_o
);

  logic [COUNT_BITS-1:0] period_q, period_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  active_q, active_d;
  logic                  one_shot_q, one_shot_d;

  always_comb begin
    period_d   = period_q;
    count_d    = count_q;
    active_d   = active_q;
    one_shot_d = one_shot_q;
    if (ctrl_i.shift) begin
      period_d   = shift_period_i;
      count_d    = shift_count_i;
      active_d   = shift_active_i;
      one_shot_d = shift_one_shot_i;
    end else if (ctrl_i.load) begin
      period_d   = load_interval_i;
      count_d    = load_interval_i;
      active_d   = 1'b1;
      one_shot_d = load_one_shot_i;
    end else if (ctrl_i.stop) begin
      active_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      one_shot_q <= 1'b0;
    end else begin
      active_q   <= active_d;
      one_shot_q <= one_shot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    count_q  <= count_d;
  end

  assign period_o   = period_q;
  assign count_o    = count_q;
  assign active_o   = active_q;
  assign one_shot_o = one_shot_q;

endmodule

/* design/tmb_head.sv */
// Shared decrementer at the head of the ring: updates one slot per tick step.
// No package dependencies.
`timescale 1ns / 1ps

module tmb_head #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  logic [COUNT_BITS-1:0] period_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic                  active_i,
  input  logic                  one_shot_i,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  active_o,
  output logic                  expire_o
);

  logic [COUNT_BITS-1:0] count_dec;

  assign count_dec = count_i - COUNT_BITS'(1);
  assign expire_o  = active_i && (count_dec == '0);

  always_comb begin
    count_o  = count_i;
    active_o = active_i;
    if (active_i) begin
      count_o = count_dec;
      if (expire_o) begin
        // A periodic slot reloads; a one-shot slot goes idle with its count at zero.
        if (one_shot_i) begin
          active_o = 1'b0;
        end else begin
          count_o = period_i;
        end
      end
    end
  end

endmodule

/* test/tb_top.sv */
// Self-checking testbench for timer_bank_tick_scheduler_core: a queue-fed command driver,
// an expiry monitor and a transaction-level predictor of the timer bank.
// Depends on tmb_pkg, tmb_in_if, tmb_out_if and the design sources.
`timescale 1ns / 1ps

module tb_top;
  import tmb_pkg::*;

  localparam int unsigned NUM_SLOTS   = 16;
  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RAND_CMDS   = 200;

  typedef struct {
    tmb_mode_e             mode;
    logic [SLOT_W-1:0]     slot;
    logic [INTERVAL_W-1:0] interval;
    logic                  one_shot;
  } timer_cmd_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              one_shot;
    logic              last;
  } expiry_t;

  logic clk;
  logic rst_n;

  tmb_in_if  in_if ();
  tmb_out_if out_if ();

  timer_bank_tick_scheduler_core #(
    .NUM_SLOTS (NUM_SLOTS),
    .COUNT_BITS(COUNT_BITS)
  ) u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // Predicted timer bank state.
  logic [COUNT_BITS-1:0] period_q [NUM_SLOTS];
  logic [COUNT_BITS-1:0] count_q  [NUM_SLOTS];
  logic                  active_q [NUM_SLOTS];
  logic                  single_q [NUM_SLOTS];

  timer_cmd_t  cmd_queue [$];
  expiry_t     expiry_q  [$];

  int unsigned cycle_cnt;
  int unsigned n_cmds;
  int unsigned n_queued;
  int unsigned n_accepted;
  int unsigned n_ticks, n_starts, n_stops, n_unused;
  int unsigned n_records;
  int unsigned max_per_tick;
  int unsigned mismatches;
  int unsigned send_gap;
  int unsigned ready_gap;
  int unsigned hold_left;
  logic        hold_done;
  logic        in_fire;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    // One stretch in four, selected by cycle counter bits 10:9, runs without any idling.
    if (((cycle_cnt >> 9) & 3) == 0) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_cmd(input tmb_mode_e m, input int unsigned s,
                         input logic [INTERVAL_W-1:0] iv, input logic os);
    timer_cmd_t c;
    c.mode     = m;
    c.slot     = SLOT_W'(s);
    c.interval = iv;
    c.one_shot = os;
    cmd_queue.push_back(c);
    n_queued++;
    if (m != MODE_NONE) n_cmds++;
  endtask

  task automatic add_tick();
    add_cmd(MODE_TICK, $urandom_range(0, NUM_SLOTS - 1), $urandom, 1'($urandom_range(0, 1)));
  endtask

  function automatic void apply_command(input timer_cmd_t c);
    expiry_t     found [NUM_SLOTS];
    int unsigned hits;
    hits = 0;
    case (c.mode)
      MODE_START: begin
        period_q[c.slot] = c.interval[COUNT_BITS-1:0];
        count_q[c.slot]  = c.interval[COUNT_BITS-1:0];
        single_q[c.slot] = c.one_shot;
        active_q[c.slot] = 1'b1;
        n_starts++;
      end
      MODE_STOP: begin
        active_q[c.slot] = 1'b0;
        n_stops++;
      end
      MODE_TICK: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (active_q[i]) begin
            count_q[i] = count_q[i] - 1'b1;
            if (count_q[i] == '0) begin
              if (single_q[i]) active_q[i] = 1'b0;
              else count_q[i] = period_q[i];
              found[hits].slot     = SLOT_W'(i);
              found[hits].one_shot = single_q[i];
              found[hits].last     = 1'b0;
              hits++;
            end
          end
        end
        for (int k = 0; k < hits; k++) begin
          found[k].last = (k == hits - 1);
          expiry_q.push_back(found[k]);
        end
        if (hits > max_per_tick) max_per_tick = hits;
        n_ticks++;
      end
      default: n_unused++;
    endcase
  endfunction

  // Monitor and predictor: both sample at the rising edge.
  always @(posedge clk) begin
    expiry_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d records still expected", cycle_cnt,
               expiry_q.size());
      $display("*** FAILED ***");
      $finish;
    end
    in_fire <= rst_n && in_if.valid && in_if.ready;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_records++;
      if (expiry_q.size() == 0) begin
        if (mismatches < 10)
          $display("Unexpected expiry record: slot %0d one_shot %0b last %0b",
                   out_if.expired_slot, out_if.was_one_shot, out_if.last);
        mismatches++;
      end else begin
        want = expiry_q.pop_front();
        if (out_if.expired_slot !== want.slot || out_if.was_one_shot !== want.one_shot ||
            out_if.last !== want.last) begin
          if (mismatches < 10)
            $display("Expiry mismatch: expected slot %0d one_shot %0b last %0b, got %0d %0b %0b",
                     want.slot, want.one_shot, want.last,
                     out_if.expired_slot, out_if.was_one_shot, out_if.last);
          mismatches++;
        end
      end
    end
    if (rst_n && in_if.valid && in_if.ready) begin
      timer_cmd_t c;
      c.mode     = tmb_mode_e'(in_if.mode);
      c.slot     = in_if.slot;
      c.interval = in_if.interval;
      c.one_shot = in_if.one_shot;
      apply_command(c);
      n_accepted++;
    end
  end

  // Long receiver hold-off, started once while the command stream is still running.
  always @(posedge clk) begin
    if (rst_n) begin
      if (!hold_done && n_accepted >= 60) begin
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // Command driver: a transaction is held until accepted, then the next one follows a random gap that may be zero.
  always @(negedge clk) begin
    timer_cmd_t c;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (in_if.valid && !in_fire) begin
      in_if.valid <= 1'b1;
    end else if (send_gap > 0) begin
      send_gap    <= send_gap - 1;
      in_if.valid <= 1'b0;
    end else if (cmd_queue.size() > 0) begin
      c = cmd_queue.pop_front();
      in_if.mode     <= c.mode;
      in_if.slot     <= c.slot;
      in_if.interval <= c.interval;
      in_if.one_shot <= c.one_shot;
      in_if.valid    <= 1'b1;
      send_gap       <= pick_gap();
    end else begin
      in_if.valid <= 1'b0;
    end
  end

  // Receiver ready with random gaps.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_if.ready <= 1'b0;
    end else if (ready_gap > 0) begin
      ready_gap    <= ready_gap - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      ready_gap    <= pick_gap();
    end
  end

  initial begin
    int unsigned pick;
    int unsigned r;
    logic [INTERVAL_W-1:0] iv;

    rst_n          = 1'b0;
    in_if.valid    = 1'b0;
    in_if.mode     = MODE_TICK;
    in_if.slot     = '0;
    in_if.interval = '0;
    in_if.one_shot = 1'b0;
    out_if.ready   = 1'b0;
    cycle_cnt = 0; n_cmds = 0; n_queued = 0; n_accepted = 0;
    n_ticks = 0; n_starts = 0; n_stops = 0; n_unused = 0;
    n_records = 0; max_per_tick = 0; mismatches = 0;
    send_gap = 0; ready_gap = 0; hold_left = 0; hold_done = 1'b0; in_fire = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      period_q[i] = '0;
      count_q[i]  = '0;
      active_q[i] = 1'b0;
      single_q[i] = 1'b0;
    end

    // Directed part: empty tick, idle stop, unused mode, both kinds of slot,
    // field extremes, reload of an active slot and a zero interval.
    add_cmd(MODE_TICK, 0, '0, 1'b0);
    add_cmd(MODE_STOP, 5, '0, 1'b0);
    add_cmd(MODE_NONE, 15, 32'hFFFF_FFFF, 1'b1);
    add_cmd(MODE_START, 0, 32'd1, 1'b1);
    add_cmd(MODE_START, 15, 32'd1, 1'b0);
    add_cmd(MODE_START, 7, 32'd2, 1'b0);
    add_cmd(MODE_TICK, 15, 32'hFFFF_FFFF, 1'b1);
    add_cmd(MODE_TICK, 0, 32'hAAAA_5555, 1'b0);
    add_cmd(MODE_START, 3, 32'hFFFF_FFFF, 1'b0);
    add_cmd(MODE_START, 4, 32'h0000_0000, 1'b1);
    add_cmd(MODE_START, 7, 32'd3, 1'b1);
    add_cmd(MODE_TICK, 0, '0, 1'b0);
    add_cmd(MODE_STOP, 15, 32'h5555_AAAA, 1'b1);
    add_cmd(MODE_TICK, 0, '0, 1'b0);
    add_cmd(MODE_TICK, 0, '0, 1'b0);

    while (n_cmds < 14 + RAND_CMDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        // Arm every slot with a short interval so that ticks fire the whole bank.
        for (int s = 0; s < NUM_SLOTS; s++)
          add_cmd(MODE_START, s, $urandom_range(1, 3), 1'($urandom_range(0, 1)));
        repeat ($urandom_range(2, 4)) add_tick();
      end else if (pick < 50) begin
        add_tick();
      end else if (pick < 80) begin
        r = $urandom_range(0, 99);
        if (r < 80) iv = $urandom_range(1, 6);
        else if (r < 94) iv = $urandom;
        else if (r < 97) iv = '0;
        else iv = 32'hFFFF_FFFF;
        add_cmd(MODE_START, $urandom_range(0, NUM_SLOTS - 1), iv, 1'($urandom_range(0, 1)));
      end else if (pick < 96) begin
        add_cmd(MODE_STOP, $urandom_range(0, NUM_SLOTS - 1), $urandom,
                1'($urandom_range(0, 1)));
      end else begin
        add_cmd(MODE_NONE, $urandom_range(0, NUM_SLOTS - 1), $urandom,
                1'($urandom_range(0, 1)));
      end
    end

    repeat (5) @(posedge clk);
    #2 rst_n = 1'b1;

    while (n_accepted != n_queued) @(posedge clk);
    while (expiry_q.size() != 0) @(posedge clk);
    // A final tick may still be rotating, and a stray record may wait out a receiver gap.
    repeat (4 * NUM_SLOTS + 100) @(posedge clk);

    $display("Drove %0d commands: %0d ticks, %0d starts, %0d stops, %0d unused-mode items.",
             n_accepted, n_ticks, n_starts, n_stops, n_unused);
    $display("Checked %0d expiry records, at most %0d from one tick, %0d mismatches.",
             n_records, max_per_tick, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
